### src/etre_pkg.sv
// shared types and constants of the transfer rate estimator
`default_nettype none

package etre_pkg;

   // field widths
   localparam int TS_W       = 48;   // timestamps and byte counts
   localparam int RATE_W     = 56;   // smoothed rate
   localparam int ALPHA_W    = 17;   // smoothing weight, Q1.16
   localparam int ALPHA_FRAC = 16;
   localparam int MS_SCALE_W = 10;   // bits added by the ms to s scaling

   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
   localparam logic [ALPHA_W-1:0] ALPHA_MIN   = 17'd655;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd13107;
   localparam logic [ALPHA_W-1:0] ALPHA_HALF  = 17'd32768;

   localparam logic [TS_W-1:0]   TS_MAX   = {TS_W{1'b1}};
   localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

   typedef struct packed {
      logic done;
      logic rem_nonzero;
   } div_status_type;

endpackage

`default_nettype wire

### src/etre_divider.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module etre_divider
   import etre_pkg::*;
#(
   parameter int NUM_W = 66,
   parameter int DEN_W = 56
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic      [NUM_W-1:0] quotient,
   output div_status_type        status
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W+1:0] diff;

   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      diff  = {1'b0, trial} - {2'b00, den_ff};

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = '0;
         quo_in  = numer;
         den_in  = denom;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // borrow means the trial remainder is below the divisor
         if (diff[DEN_W+1]) begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end else begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient           = quo_ff;
   assign status.done        = done_ff;
   assign status.rem_nonzero = (rem_ff != '0);

endmodule

`default_nettype wire

### src/ewma_transfer_rate_estimator_unit.sv
// ewma transfer rate estimator: one progress sample in, one rate report out
// a first sample is only recorded; a stale sample skips the rate division; a sample that
//   yields a new rate divides for the rate, may blend it and may divide for the remaining time
// one transaction at a time, set by the shared bit-serial divider that handles both the
//   rate and the remaining time, and by the shift-add blend
// reset: synchronous, clears the sample history and rate, alpha returns to 0.2
`default_nettype none

module ewma_transfer_rate_estimator_unit
   import etre_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [TS_W-1:0]    req_now_ms,
   input  wire logic [TS_W-1:0]    req_confirmed_bytes,
   input  wire logic [TS_W-1:0]    req_total_bytes,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_rate_valid,
   output logic      [RATE_W-1:0]  rsp_rate_q8,
   output logic                    rsp_remaining_valid,
   output logic      [TS_W-1:0]    rsp_remaining_seconds,
   input  wire logic               csr_we,
   input  wire logic [ALPHA_W-1:0] csr_wdata
);

   localparam int NUM_W     = TS_W + MS_SCALE_W + FRAC_BITS;
   localparam int ACC_W     = RATE_W + ALPHA_FRAC;
   localparam int MUL_CNT_W = $clog2(ALPHA_W + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_RATE_START,
      S_RATE_WAIT,
      S_MUL,
      S_EMIT,
      S_REM_WAIT,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [ALPHA_W-1:0] alpha_ff, alpha_in;
   logic               seen_first_ff, seen_first_in;
   logic               have_rate_ff, have_rate_in;
   logic [TS_W-1:0]    prev_ms_ff, prev_ms_in;
   logic [TS_W-1:0]    prev_bytes_ff, prev_bytes_in;
   logic [RATE_W-1:0]  smoothed_ff, smoothed_in;

   logic [TS_W-1:0]    in_ms_ff, in_ms_in;
   logic [TS_W-1:0]    in_conf_ff, in_conf_in;
   logic [TS_W-1:0]    in_total_ff, in_total_in;
   logic [TS_W-1:0]    d_bytes_ff, d_bytes_in;
   logic [TS_W-1:0]    d_ms_ff, d_ms_in;

   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [ACC_W-1:0]     inst_sh_ff, inst_sh_in;
   logic [ACC_W-1:0]     sm_sh_ff, sm_sh_in;
   logic [ALPHA_W-1:0]   alpha_sh_ff, alpha_sh_in;
   logic [ALPHA_W-1:0]   beta_sh_ff, beta_sh_in;
   logic [MUL_CNT_W-1:0] mul_cnt_ff, mul_cnt_in;

   logic               res_rate_valid_ff, res_rate_valid_in;
   logic [RATE_W-1:0]  res_rate_ff, res_rate_in;
   logic               res_rem_valid_ff, res_rem_valid_in;
   logic [TS_W-1:0]    res_rem_secs_ff, res_rem_secs_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_rate_valid_ff, rsp_rate_valid_in;
   logic [RATE_W-1:0]  rsp_rate_q8_ff, rsp_rate_q8_in;
   logic               rsp_rem_valid_ff, rsp_rem_valid_in;
   logic [TS_W-1:0]    rsp_rem_secs_ff, rsp_rem_secs_in;

   logic               div_start;
   logic [NUM_W-1:0]   div_numer;
   logic [RATE_W-1:0]  div_denom;
   logic [NUM_W-1:0]   div_quotient;
   div_status_type     div_status;

   logic [NUM_W-1:0]   bytes_ext;
   logic [NUM_W-1:0]   rate_numer;
   logic [NUM_W-1:0]   rem_numer;
   logic [RATE_W-1:0]  inst_sat;
   logic [TS_W-1:0]    rem_sat;
   logic [ACC_W-1:0]   acc_next;
   logic               need_rem;

   etre_divider #(
      .NUM_W (NUM_W),
      .DEN_W (RATE_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .quotient (div_quotient),
      .status   (div_status)
   );

   always_comb begin
      // delta bytes times 1000 as 1024 - 16 - 8
      bytes_ext  = NUM_W'(d_bytes_ff);
      rate_numer = ((bytes_ext << 10) - (bytes_ext << 4) - (bytes_ext << 3)) << FRAC_BITS;
      rem_numer  = NUM_W'(in_total_ff - in_conf_ff) << FRAC_BITS;

      need_rem  = have_rate_ff && (smoothed_ff != '0) && (in_total_ff > in_conf_ff);
      div_start = (state_ff == S_RATE_START) || ((state_ff == S_EMIT) && need_rem);
      if (state_ff == S_RATE_START) begin
         div_numer = rate_numer;
         div_denom = RATE_W'(d_ms_ff);
      end else begin
         div_numer = rem_numer;
         div_denom = smoothed_ff;
      end

      inst_sat = (div_quotient >= NUM_W'(RATE_MAX)) ? RATE_MAX : div_quotient[RATE_W-1:0];
      // ceiling, saturated to the 48-bit maximum
      rem_sat  = (div_quotient >= NUM_W'(TS_MAX)) ? TS_MAX :
                 div_quotient[TS_W-1:0] + TS_W'(div_status.rem_nonzero);

      acc_next = acc_ff + (alpha_sh_ff[0] ? inst_sh_ff : '0) + (beta_sh_ff[0] ? sm_sh_ff : '0);
   end

   always_comb begin
      state_in          = state_ff;
      alpha_in          = alpha_ff;
      seen_first_in     = seen_first_ff;
      have_rate_in      = have_rate_ff;
      prev_ms_in        = prev_ms_ff;
      prev_bytes_in     = prev_bytes_ff;
      smoothed_in       = smoothed_ff;
      in_ms_in          = in_ms_ff;
      in_conf_in        = in_conf_ff;
      in_total_in       = in_total_ff;
      d_bytes_in        = d_bytes_ff;
      d_ms_in           = d_ms_ff;
      acc_in            = acc_ff;
      inst_sh_in        = inst_sh_ff;
      sm_sh_in          = sm_sh_ff;
      alpha_sh_in       = alpha_sh_ff;
      beta_sh_in        = beta_sh_ff;
      mul_cnt_in        = mul_cnt_ff;
      res_rate_valid_in = res_rate_valid_ff;
      res_rate_in       = res_rate_ff;
      res_rem_valid_in  = res_rem_valid_ff;
      res_rem_secs_in   = res_rem_secs_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_rate_valid_in = rsp_rate_valid_ff;
      rsp_rate_q8_in    = rsp_rate_q8_ff;
      rsp_rem_valid_in  = rsp_rem_valid_ff;
      rsp_rem_secs_in   = rsp_rem_secs_ff;

      if (csr_we) begin
         if (csr_wdata < ALPHA_MIN) begin
            alpha_in = ALPHA_MIN;
         end else if (csr_wdata > ALPHA_ONE) begin
            alpha_in = ALPHA_ONE;
         end else begin
            alpha_in = csr_wdata;
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               in_ms_in    = req_now_ms;
               in_conf_in  = req_confirmed_bytes;
               in_total_in = req_total_bytes;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!seen_first_ff) begin
               seen_first_in     = 1'b1;
               prev_ms_in        = in_ms_ff;
               prev_bytes_in     = in_conf_ff;
               res_rate_valid_in = 1'b0;
               res_rate_in       = '0;
               res_rem_valid_in  = 1'b0;
               res_rem_secs_in   = '0;
               state_in          = S_OUT;
            end else if ((in_ms_ff <= prev_ms_ff) || (in_conf_ff < prev_bytes_ff)) begin
               // stale sample: report without touching the history
               state_in = S_EMIT;
            end else begin
               d_bytes_in = in_conf_ff - prev_bytes_ff;
               d_ms_in    = in_ms_ff - prev_ms_ff;
               state_in   = S_RATE_START;
            end
         end
         S_RATE_START: begin
            state_in = S_RATE_WAIT;
         end
         S_RATE_WAIT: begin
            if (div_status.done) begin
               prev_ms_in    = in_ms_ff;
               prev_bytes_in = in_conf_ff;
               if (inst_sat == '0) begin
                  state_in = S_EMIT;
               end else if (have_rate_ff) begin
                  acc_in      = ACC_W'(ALPHA_HALF);
                  inst_sh_in  = ACC_W'(inst_sat);
                  sm_sh_in    = ACC_W'(smoothed_ff);
                  alpha_sh_in = alpha_ff;
                  beta_sh_in  = ALPHA_ONE - alpha_ff;
                  mul_cnt_in  = MUL_CNT_W'(ALPHA_W);
                  state_in    = S_MUL;
               end else begin
                  smoothed_in  = inst_sat;
                  have_rate_in = 1'b1;
                  state_in     = S_EMIT;
               end
            end
         end
         S_MUL: begin
            // alpha*inst + (1-alpha)*smoothed, one weight bit per cycle
            acc_in      = acc_next;
            inst_sh_in  = inst_sh_ff << 1;
            sm_sh_in    = sm_sh_ff << 1;
            alpha_sh_in = alpha_sh_ff >> 1;
            beta_sh_in  = beta_sh_ff >> 1;
            mul_cnt_in  = mul_cnt_ff - MUL_CNT_W'(1);
            if (mul_cnt_ff == MUL_CNT_W'(1)) begin
               smoothed_in = acc_next[ACC_W-1:ALPHA_FRAC];
               state_in    = S_EMIT;
            end
         end
         S_EMIT: begin
            res_rate_valid_in = have_rate_ff;
            res_rate_in       = have_rate_ff ? smoothed_ff : '0;
            res_rem_valid_in  = need_rem;
            res_rem_secs_in   = '0;
            state_in          = need_rem ? S_REM_WAIT : S_OUT;
         end
         S_REM_WAIT: begin
            if (div_status.done) begin
               res_rem_secs_in = rem_sat;
               state_in        = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_rate_valid_in = res_rate_valid_ff;
               rsp_rate_q8_in    = res_rate_ff;
               rsp_rem_valid_in  = res_rem_valid_ff;
               rsp_rem_secs_in   = res_rem_secs_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         alpha_ff      <= ALPHA_RESET;
         seen_first_ff <= 1'b0;
         have_rate_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         alpha_ff      <= alpha_in;
         seen_first_ff <= seen_first_in;
         have_rate_ff  <= have_rate_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      prev_ms_ff        <= prev_ms_in;
      prev_bytes_ff     <= prev_bytes_in;
      smoothed_ff       <= smoothed_in;
      in_ms_ff          <= in_ms_in;
      in_conf_ff        <= in_conf_in;
      in_total_ff       <= in_total_in;
      d_bytes_ff        <= d_bytes_in;
      d_ms_ff           <= d_ms_in;
      acc_ff            <= acc_in;
      inst_sh_ff        <= inst_sh_in;
      sm_sh_ff          <= sm_sh_in;
      alpha_sh_ff       <= alpha_sh_in;
      beta_sh_ff        <= beta_sh_in;
      mul_cnt_ff        <= mul_cnt_in;
      res_rate_valid_ff <= res_rate_valid_in;
      res_rate_ff       <= res_rate_in;
      res_rem_valid_ff  <= res_rem_valid_in;
      res_rem_secs_ff   <= res_rem_secs_in;
      rsp_rate_valid_ff <= rsp_rate_valid_in;
      rsp_rate_q8_ff    <= rsp_rate_q8_in;
      rsp_rem_valid_ff  <= rsp_rem_valid_in;
      rsp_rem_secs_ff   <= rsp_rem_secs_in;
   end

   assign req_ready             = (state_ff == S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_rate_valid        = rsp_rate_valid_ff;
   assign rsp_rate_q8           = rsp_rate_q8_ff;
   assign rsp_remaining_valid   = rsp_rem_valid_ff;
   assign rsp_remaining_seconds = rsp_rem_secs_ff;

   // alpha stays clamped to its legal range
   a_alpha_range: assert property (@(posedge clock) disable iff (reset)
      (alpha_ff >= ALPHA_MIN) && (alpha_ff <= ALPHA_ONE))
      else $error("alpha out of range");

   // a rate never exists before the first sample was recorded
   a_rate_after_first: assert property (@(posedge clock) disable iff (reset)
      have_rate_ff |-> seen_first_ff)
      else $error("rate without first sample");

   // one transaction at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction accepted while busy");

   // a remaining time is only reported with a nonzero rate
   a_remaining_needs_rate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_remaining_valid) |-> (rsp_rate_valid && (rsp_rate_q8 != '0)))
      else $error("remaining time without rate");

endmodule

`default_nettype wire
